### rtl/fpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy PD controller package
// Shared widths, codes and types of the fuzzy PD controller.
// ----------------------------------------------------------------------------
package fpd_pkg;

   localparam int NUM_SETS        = 5;
   localparam int RULE_COUNT      = NUM_SETS * NUM_SETS;
   localparam int DATA_W          = 16;
   localparam int CSR_W           = 15;
   localparam int CSR_IDX_W       = 2;
   localparam int SPAN_W          = 15;
   localparam int MU_W            = 16;
   localparam int SEG_W           = 2;
   localparam int IDX_W           = 5;
   localparam int DIV_STEPS       = 16;
   localparam int NUM_BANKS       = 4;
   localparam int BANK_DEPTH      = 9;
   localparam int BANK_AW         = $clog2(BANK_DEPTH);
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [MU_W-1:0] MU_FULL = 16'h8000;

   localparam logic OPC_EVAL  = 1'b0;
   localparam logic OPC_WRITE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ERR_SMALL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_BIG    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERR_SMALL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DERR_BIG   = 2'd3;

   localparam logic [CSR_W-1:0] ERR_SMALL_RST = 15'd256;
   localparam logic [CSR_W-1:0] ERR_BIG_RST   = 15'd512;

   typedef struct packed {
      logic [CSR_W-1:0] err_small;
      logic [CSR_W-1:0] err_big;
      logic [CSR_W-1:0] derr_small;
      logic [CSR_W-1:0] derr_big;
   } fpd_csr_type;

   typedef struct packed {
      logic [SEG_W-1:0]  seg;
      logic [SPAN_W-1:0] off;
      logic [SPAN_W-1:0] span;
   } fpd_axis_type;

   typedef struct packed {
      logic                     opcode;
      logic [IDX_W-1:0]         rule_index;
      logic signed [DATA_W-1:0] rule_level;
      fpd_axis_type             err;
      fpd_axis_type             rate;
   } fpd_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fpd_qstat_type;

endpackage

### rtl/fpd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 9
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fpd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy PD front end
// Accepts requests, finds the set segment of both inputs and pushes the
// classified request into the queue.
// ----------------------------------------------------------------------------
module fpd_front import fpd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic [IDX_W-1:0]         req_rule_index,
   input  logic signed [DATA_W-1:0] req_rule_level,
   input  logic signed [DATA_W-1:0] req_error_in,
   input  logic signed [DATA_W-1:0] req_error_rate,
   input  fpd_csr_type              csr,
   input  fpd_qstat_type            qstat,
   output logic                     push,
   output fpd_item_type             push_item
);

   function automatic fpd_axis_type classify(input logic signed [DATA_W-1:0] x,
                                             input logic [CSR_W-1:0] pk_in,
                                             input logic [CSR_W-1:0] pk_out);
      logic [CSR_W-1:0]  s_eff;
      logic [CSR_W:0]    b_eff;
      logic [SPAN_W-1:0] outer;
      logic signed [CSR_W+1:0] xs;
      logic signed [CSR_W+1:0] ps;
      logic signed [CSR_W+1:0] pb;
      logic signed [CSR_W+1:0] d;
      fpd_axis_type a;
      s_eff = (pk_in == '0) ? CSR_W'(1) : pk_in;
      b_eff = (pk_out <= s_eff) ? {1'b0, s_eff} + (CSR_W+1)'(1) : {1'b0, pk_out};
      outer = SPAN_W'(b_eff - {1'b0, s_eff});
      xs    = {x[DATA_W-1], x};
      ps    = {2'b00, s_eff};
      pb    = {1'b0, b_eff};
      d     = '0;
      a     = '0;
      if (xs <= -pb) begin
         a.seg  = 2'd0;
         a.span = outer;
      end else if (xs <= -ps) begin
         d      = xs + pb;
         a.seg  = 2'd0;
         a.off  = d[SPAN_W-1:0];
         a.span = outer;
      end else if (xs <= 0) begin
         d      = xs + ps;
         a.seg  = 2'd1;
         a.off  = d[SPAN_W-1:0];
         a.span = s_eff;
      end else if (xs <= ps) begin
         a.seg  = 2'd2;
         a.off  = xs[SPAN_W-1:0];
         a.span = s_eff;
      end else if (xs <= pb) begin
         d      = xs - ps;
         a.seg  = 2'd3;
         a.off  = d[SPAN_W-1:0];
         a.span = outer;
      end else begin
         a.seg  = 2'd3;
         a.off  = outer;
         a.span = outer;
      end
      return a;
   endfunction

   fpd_item_type item_ff;
   fpd_item_type item_in;
   logic         valid_ff;
   logic         valid_in;
   logic         load;

   assign req_stall = valid_ff & qstat.full;
   assign push      = valid_ff & ~qstat.full;
   assign load      = req_valid & ~req_stall;
   assign push_item = item_ff;

   always_comb begin
      item_in.opcode     = req_opcode;
      item_in.rule_index = req_rule_index;
      item_in.rule_level = req_rule_level;
      item_in.err        = classify(req_error_in, csr.err_small, csr.err_big);
      item_in.rate       = classify(req_error_rate, csr.derr_small, csr.derr_big);
      if (load) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

endmodule

### rtl/fpd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy PD request queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module fpd_queue import fpd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  fpd_item_type  push_item,
   input  logic          pop,
   output fpd_item_type  head_item,
   output fpd_qstat_type qstat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   fpd_item_type    mem_ff [0:DEPTH-1];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff;
   logic [AW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item   = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == CW'(DEPTH));
   assign qstat.empty = (count_ff == '0);

endmodule

### rtl/fpd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy PD back end
// Membership division, rule table, weighted sum and final division.
// ----------------------------------------------------------------------------
module fpd_back import fpd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  fpd_item_type             head_item,
   input  fpd_qstat_type            qstat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_control_out
);

   typedef struct packed {
      logic                     opcode;
      logic [IDX_W-1:0]         rule_index;
      logic signed [DATA_W-1:0] rule_level;
      logic [SEG_W-1:0]         seg_e;
      logic [SEG_W-1:0]         seg_r;
      logic [SPAN_W-1:0]        span_e;
      logic [SPAN_W-1:0]        span_r;
      logic [MU_W-1:0]          rem_e;
      logic [MU_W-1:0]          quo_e;
      logic [MU_W-1:0]          rem_r;
      logic [MU_W-1:0]          quo_r;
   } mu_stage_type;

   typedef struct packed {
      logic [MU_W:0]     rem;
      logic [DATA_W-1:0] ql;
      logic [MU_W:0]     den;
      logic              neg;
   } div_stage_type;

   function automatic logic [2*MU_W-1:0] mu_step(input logic [MU_W-1:0] rem,
                                                 input logic [MU_W-1:0] quo,
                                                 input logic [SPAN_W-1:0] span,
                                                 input logic first);
      logic [MU_W-1:0] t;
      logic            ge;
      t  = first ? rem : {rem[MU_W-2:0], 1'b0};
      ge = (t >= {1'b0, span});
      return {(ge ? t - {1'b0, span} : t), {quo[MU_W-2:0], ge}};
   endfunction

   function automatic logic [BANK_AW-1:0] bank_addr(input logic [2:0] e,
                                                    input logic [2:0] r);
      return BANK_AW'({1'b0, e[2:1], 1'b0}) + BANK_AW'({2'b00, e[2:1]})
             + BANK_AW'({2'b00, r[2:1]});
   endfunction

   logic adv;
   logic out_vld_ff;

   // membership division
   mu_stage_type mu_ff [0:DIV_STEPS];
   mu_stage_type mu_nx [0:DIV_STEPS-1];
   logic [DIV_STEPS:0] mvld_ff;
   mu_stage_type mu_in;

   assign rsp_valid = out_vld_ff;
   assign adv       = ~out_vld_ff | ~rsp_stall;
   assign pop       = adv & ~qstat.empty;

   always_comb begin
      mu_in.opcode     = head_item.opcode;
      mu_in.rule_index = head_item.rule_index;
      mu_in.rule_level = head_item.rule_level;
      mu_in.seg_e      = head_item.err.seg;
      mu_in.seg_r      = head_item.rate.seg;
      mu_in.span_e     = head_item.err.span;
      mu_in.span_r     = head_item.rate.span;
      mu_in.rem_e      = {1'b0, head_item.err.off};
      mu_in.rem_r      = {1'b0, head_item.rate.off};
      mu_in.quo_e      = '0;
      mu_in.quo_r      = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mu_ff[0] <= mu_in;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_mu
      always_comb begin
         mu_nx[j] = mu_ff[j];
         {mu_nx[j].rem_e, mu_nx[j].quo_e} =
            mu_step(mu_ff[j].rem_e, mu_ff[j].quo_e, mu_ff[j].span_e, 1'(j == 0));
         {mu_nx[j].rem_r, mu_nx[j].quo_r} =
            mu_step(mu_ff[j].rem_r, mu_ff[j].quo_r, mu_ff[j].span_r, 1'(j == 0));
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            mu_ff[j+1] <= mu_nx[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvld_ff <= '0;
      end else if (adv) begin
         mvld_ff <= {mvld_ff[DIV_STEPS-1:0], pop};
      end
   end

   // rule table access
   mu_stage_type    mt;
   logic            m_vld;
   logic [MU_W-1:0] up_e;
   logic [MU_W-1:0] lo_e;
   logic [MU_W-1:0] up_r;
   logic [MU_W-1:0] lo_r;
   logic [2:0]      wr_e;
   logic [2:0]      wr_r;
   logic [IDX_W-1:0] e5;
   logic [1:0]       wr_bank;
   logic [BANK_AW-1:0] wr_addr;
   logic             wr_ok;

   assign mt    = mu_ff[DIV_STEPS];
   assign m_vld = mvld_ff[DIV_STEPS];
   assign up_e  = mt.quo_e;
   assign lo_e  = MU_FULL - mt.quo_e;
   assign up_r  = mt.quo_r;
   assign lo_r  = MU_FULL - mt.quo_r;

   always_comb begin
      if (mt.rule_index >= IDX_W'(20)) begin
         wr_e = 3'd4;
      end else if (mt.rule_index >= IDX_W'(15)) begin
         wr_e = 3'd3;
      end else if (mt.rule_index >= IDX_W'(10)) begin
         wr_e = 3'd2;
      end else if (mt.rule_index >= IDX_W'(5)) begin
         wr_e = 3'd1;
      end else begin
         wr_e = 3'd0;
      end
      e5      = {wr_e, 2'b00} + {2'b00, wr_e};
      wr_r    = 3'(mt.rule_index - e5);
      wr_bank = {wr_e[0], wr_r[0]};
      wr_addr = bank_addr(wr_e, wr_r);
      wr_ok   = (mt.rule_index < IDX_W'(RULE_COUNT));
   end

   logic [MU_W-1:0]        w_ff   [0:NUM_BANKS-1];
   logic [NUM_BANKS-1:0]   rv_ff;
   logic                   pvld_ff;
   logic [DATA_W-1:0]      rdata  [0:NUM_BANKS-1];
   logic signed [31:0]     prod_ff [0:NUM_BANKS-1];
   logic [MU_W:0]          den_ff;
   logic                   qvld_ff;

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      localparam logic PE = 1'((b >> 1) & 1);
      localparam logic PR = 1'(b & 1);
      logic [2:0]          e;
      logic [2:0]          r;
      logic [MU_W-1:0]     we;
      logic [MU_W-1:0]     wr;
      logic [MU_W-1:0]     w;
      logic [BANK_AW-1:0]  raddr;
      logic                wen;
      logic [BANK_DEPTH-1:0] vbit_ff;
      logic signed [DATA_W-1:0] lvl;
      logic signed [32:0]  p;

      always_comb begin
         if (mt.seg_e[0] == PE) begin
            e  = {1'b0, mt.seg_e};
            we = lo_e;
         end else begin
            e  = {1'b0, mt.seg_e} + 3'd1;
            we = up_e;
         end
         if (mt.seg_r[0] == PR) begin
            r  = {1'b0, mt.seg_r};
            wr = lo_r;
         end else begin
            r  = {1'b0, mt.seg_r} + 3'd1;
            wr = up_r;
         end
         w     = (we < wr) ? we : wr;
         raddr = bank_addr(e, r);
         wen   = adv & m_vld & (mt.opcode == OPC_WRITE) & wr_ok & (wr_bank == 2'(b));
      end

      fpd_ram #(
         .WIDTH (DATA_W),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wen),
         .wr_addr (wr_addr),
         .wr_data (mt.rule_level),
         .rd_en   (adv),
         .rd_addr (raddr),
         .rd_data (rdata[b])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            vbit_ff <= '0;
         end else if (wen) begin
            vbit_ff[wr_addr] <= 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            w_ff[b]  <= w;
            rv_ff[b] <= vbit_ff[raddr];
         end
      end

      always_comb begin
         lvl = rv_ff[b] ? $signed(rdata[b]) : '0;
         p   = lvl * $signed({1'b0, w_ff[b]});
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            prod_ff[b] <= p[31:0];
         end
      end
   end

   logic [MU_W+1:0] den_sum;

   assign den_sum = {2'b00, w_ff[0]} + {2'b00, w_ff[1]} + {2'b00, w_ff[2]}
                    + {2'b00, w_ff[3]};

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff <= den_sum[MU_W:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
         qvld_ff <= 1'b0;
      end else if (adv) begin
         pvld_ff <= m_vld & (mt.opcode == OPC_EVAL);
         qvld_ff <= pvld_ff;
      end
   end

   // final division
   div_stage_type d_ff [0:DIV_STEPS];
   div_stage_type d_nx [0:DIV_STEPS-1];
   div_stage_type d_in;
   logic [DIV_STEPS:0] dvld_ff;
   logic signed [31:0] num;
   logic [31:0]        mag;

   always_comb begin
      num      = prod_ff[0] + prod_ff[1] + prod_ff[2] + prod_ff[3];
      mag      = num[31] ? 32'(-num) : 32'(num);
      d_in.rem = {1'b0, mag[31:16]};
      d_in.ql  = mag[15:0];
      d_in.den = den_ff;
      d_in.neg = num[31];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff[0] <= d_in;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [MU_W+1:0] t;
      logic            ge;
      always_comb begin
         t          = {d_ff[k].rem, d_ff[k].ql[DATA_W-1]};
         ge         = (t >= {1'b0, d_ff[k].den});
         d_nx[k]    = d_ff[k];
         d_nx[k].rem = ge ? (MU_W+1)'(t - {1'b0, d_ff[k].den}) : t[MU_W:0];
         d_nx[k].ql  = {d_ff[k].ql[DATA_W-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            d_ff[k+1] <= d_nx[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff <= '0;
      end else if (adv) begin
         dvld_ff <= {dvld_ff[DIV_STEPS-1:0], qvld_ff};
      end
   end

   // output register
   logic [DATA_W-1:0]        out_ff;
   logic [DATA_W-1:0]        res;

   assign res = d_ff[DIV_STEPS].neg ? DATA_W'(-d_ff[DIV_STEPS].ql) : d_ff[DIV_STEPS].ql;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= dvld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= res;
      end
   end

   assign rsp_control_out = $signed(out_ff);

endmodule

### rtl/fuzzy_pd_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy PD controller unit
// 5x5 rule base, triangular sets, min inference, weighted-average output.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    opcode, rule_index, rule_level,
//                                         error_in, error_rate
// rsp_      out        rsp_valid/stall    control_out
// csr_      in         csr_valid/ready    csr_index, csr_wdata
//
// One request per cycle sustained when nothing stalls. An evaluation passes
// through the two 16-step quotient pipelines before its result returns.
// A rule write returns nothing. Reset clears the rule table valid bits and
// loads the breakpoint registers. A stall on rsp_ freezes the back end; the
// queue and front register then absorb requests before req_stall rises.
// ----------------------------------------------------------------------------
module fuzzy_pd_controller_unit import fpd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic [IDX_W-1:0]         req_rule_index,
   input  logic signed [DATA_W-1:0] req_rule_level,
   input  logic signed [DATA_W-1:0] req_error_in,
   input  logic signed [DATA_W-1:0] req_error_rate,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_control_out,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   fpd_csr_type   csr_ff;
   fpd_csr_type   csr_in;
   fpd_qstat_type qstat;
   fpd_item_type  push_item;
   fpd_item_type  head_item;
   logic          push;
   logic          pop;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ERR_SMALL:  csr_in.err_small  = csr_wdata;
            CSR_ERR_BIG:    csr_in.err_big    = csr_wdata;
            CSR_DERR_SMALL: csr_in.derr_small = csr_wdata;
            CSR_DERR_BIG:   csr_in.derr_big   = csr_wdata;
            default:        csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.err_small  <= ERR_SMALL_RST;
         csr_ff.err_big    <= ERR_BIG_RST;
         csr_ff.derr_small <= ERR_SMALL_RST;
         csr_ff.derr_big   <= ERR_BIG_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   fpd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_rule_index (req_rule_index),
      .req_rule_level (req_rule_level),
      .req_error_in   (req_error_in),
      .req_error_rate (req_error_rate),
      .csr            (csr_ff),
      .qstat          (qstat),
      .push           (push),
      .push_item      (push_item)
   );

   fpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   fpd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_item       (head_item),
      .qstat           (qstat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_control_out (rsp_control_out)
   );

endmodule
